/* sv/pct_pkg.sv */
`timescale 1ns / 1ps

package pct_pkg;

	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_UPPER = 8'h41;
	localparam logic [7:0] CASE_BIT   = 8'h20;
	localparam logic [7:0] HEX_LETTER_OFFSET = 8'd10;
	localparam int unsigned NIBBLE_BITS = 4;
	localparam int unsigned MAX_BEATS = 3;

	// One queued command: up to three output bytes produced by one input byte.
	typedef struct packed {
		logic [1:0]                 count;
		logic                       last;
		logic [MAX_BEATS-1:0][7:0]  data;
	} pct_cmd_t;

	function automatic logic is_hex(input logic [7:0] c);
		logic lc;
		begin
			lc = ((c | CASE_BIT) >= 8'h61) && ((c | CASE_BIT) <= 8'h66);
			is_hex = ((c >= 8'h30) && (c <= 8'h39)) || lc;
		end
	endfunction

	function automatic logic [NIBBLE_BITS-1:0] hex_value(input logic [7:0] c);
		logic [7:0] t;
		begin
			if (c < CHAR_UPPER) begin
				t = c - CHAR_ZERO;
			end else begin
				t = (c & ~CASE_BIT) - CHAR_UPPER + HEX_LETTER_OFFSET;
			end
			hex_value = t[NIBBLE_BITS-1:0];
		end
	endfunction

endpackage

/* sv/pct_in_if.sv */
`timescale 1ns / 1ps

interface pct_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

/* sv/pct_out_if.sv */
`timescale 1ns / 1ps

interface pct_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

/* sv/pct_front.sv */
`timescale 1ns / 1ps

module pct_front
	import pct_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	pct_in_if.sink   enc,
	input  logic     full,
	output logic     push,
	output pct_cmd_t push_cmd
);

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_PCT,
		HOLD_DIGIT
	} hold_t;

	hold_t      hold_q;
	logic [7:0] digit_q;

	hold_t      hold_d;
	logic [7:0] digit_d;
	logic       fresh;
	logic [1:0] n;
	logic [7:0] value;
	logic       accept;

	assign enc.ready = !full;
	assign accept    = enc.valid && enc.ready;

	always_comb begin
		hold_d        = HOLD_NONE;
		digit_d       = digit_q;
		fresh         = 1'b0;
		n             = 2'd0;
		value         = {hex_value(digit_q), hex_value(enc.in_byte)};
		push_cmd.data = '0;
		push_cmd.last = enc.in_last;
		unique case (hold_q)
			HOLD_PCT: begin
				if (is_hex(enc.in_byte) && !enc.in_last) begin
					hold_d  = HOLD_DIGIT;
					digit_d = enc.in_byte;
				end else begin
					push_cmd.data[0] = PCT_CHAR;
					n                = 2'd1;
					fresh            = 1'b1;
				end
			end
			HOLD_DIGIT: begin
				if (is_hex(enc.in_byte) && (value != 8'd0)) begin
					push_cmd.data[0] = value;
					n                = 2'd1;
				end else begin
					push_cmd.data[0] = PCT_CHAR;
					push_cmd.data[1] = digit_q;
					n                = 2'd2;
					fresh            = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			if ((enc.in_byte == PCT_CHAR) && !enc.in_last) begin
				hold_d = HOLD_PCT;
			end else begin
				push_cmd.data[n] = enc.in_byte;
				n                = n + 2'd1;
			end
		end
		push_cmd.count = n;
		push           = accept && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_NONE;
		end else if (accept) begin
			hold_q <= hold_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			digit_q <= digit_d;
		end
	end

	a_last_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && enc.in_last |=> hold_q == HOLD_NONE)
		else $error("held bytes survived the final byte of a string");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && enc.in_last |-> push)
		else $error("final byte produced no output");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into a full queue");

endmodule

/* sv/pct_queue.sv */
`timescale 1ns / 1ps

module pct_queue
	import pct_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pct_cmd_t push_cmd,
	input  logic     pop,
	output logic     full,
	output logic     head_valid,
	output pct_cmd_t head_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	pct_cmd_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == DEPTH_CNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* sv/pct_back.sv */
`timescale 1ns / 1ps

module pct_back
	import pct_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  pct_cmd_t head_cmd,
	output logic     pop,
	pct_out_if.source dec
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic       load;
	logic       final_beat;

	assign dec.valid    = out_valid_q;
	assign dec.out_byte = out_byte_q;
	assign dec.out_last = out_last_q;

	assign load       = head_valid && (!out_valid_q || dec.ready);
	assign final_beat = (idx_q == (head_cmd.count - 2'd1));
	assign pop        = load && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_beat ? 2'd0 : idx_q + 2'd1;
			end else if (dec.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head_cmd.data[idx_q];
			out_last_q <= head_cmd.last && final_beat;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q < head_cmd.count)
		else $error("beat index ran past the queued command");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> idx_q == 2'd0)
		else $error("beat index left nonzero with an empty queue");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("command retired without driving a beat");

endmodule

/* sv/percent_decoder_unit.sv */
`timescale 1ns / 1ps

// URL percent decoder. Encoded text enters on enc one byte per beat, with
// in_last set on the final byte of a string, and decoded bytes leave on dec
// with out_last set on the final decoded byte. A '%' followed by two hex
// digits of either case becomes one byte; "%00" and any '%' not followed by
// two hex digits pass through literally, and bytes still held when a string
// ends are flushed literally. The block takes one input byte per clock cycle
// as long as its command queue has room. Each input byte makes zero to three
// output bytes; the output side sends one byte per cycle while dec is ready,
// so a run of input bytes that each expand to several outputs fills the
// QUEUE_DEPTH-entry queue and then stalls the input. An accepted byte's
// output passes through the command queue and then the output register
// before it reaches dec.

module percent_decoder_unit
	import pct_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	pct_in_if.sink    enc,
	pct_out_if.source dec
);

	// The front end tracks the pending escape and turns each input byte that
	// releases bytes into a command holding them.
	logic     push;
	pct_cmd_t push_cmd;
	logic     full;

	// The back end walks each command one output beat at a time.
	logic     pop;
	logic     head_valid;
	pct_cmd_t head_cmd;

	pct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.enc      (enc),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pct_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	pct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.dec        (dec)
	);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the percent decoder. Encoded text goes in on the
// enc channel one beat at a time and every decoded beat on the dec channel
// is compared with what a local model of the decoder says it should be.
module tb_top;
	import pct_pkg::*;

	// Character classes the local model needs.
	localparam logic [7:0] DIGIT_0   = 8'h30;
	localparam logic [7:0] DIGIT_9   = 8'h39;
	localparam logic [7:0] UPPER_A   = 8'h41;
	localparam logic [7:0] UPPER_F   = 8'h46;
	localparam logic [7:0] LOWER_A   = 8'h61;
	localparam logic [7:0] LOWER_F   = 8'h66;
	localparam logic [7:0] FOLD_CASE = 8'h20;

	localparam int RANDOM_CHARS = 300;
	localparam int CALM_AFTER   = 240;
	localparam int DRAIN_AT     = 150;
	localparam int HOLD_CYCLES  = 80;
	localparam int TAIL_CYCLES  = 8;
	localparam int TIMEOUT_NS   = 2_000_000;

	// One decoded beat as it should appear on the dec channel.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} dec_beat_t;

	// One row of encoded text. When fixed is set, the expected beats are
	// spelled out in the row; otherwise the local model supplies them.
	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       fixed;
		logic [1:0] n;
		logic [7:0] e0;
		logic [7:0] e1;
		logic [7:0] e2;
		logic       el;
	} enc_row_t;

	localparam int DIRECTED_N = 27;
	localparam enc_row_t DIRECTED [DIRECTED_N] = '{
		// Plain bytes, including the smallest nonzero code and the largest code.
		'{8'h61, 1'b0, 1'b1, 2'd1, 8'h61, 8'h00, 8'h00, 1'b0},
		'{8'h01, 1'b0, 1'b1, 2'd1, 8'h01, 8'h00, 8'h00, 1'b0},
		'{8'hFF, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00, 1'b0},
		// "%41" decodes to 'A'.
		'{8'h25, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h34, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h31, 1'b0, 1'b1, 2'd1, 8'h41, 8'h00, 8'h00, 1'b0},
		// "%00" is never decoded and comes out as three literal bytes.
		'{8'h25, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h30, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h30, 1'b0, 1'b1, 2'd3, 8'h25, 8'h30, 8'h30, 1'b0},
		// "%fF" mixes both cases and decodes to the top code.
		'{8'h25, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h66, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h46, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00, 1'b0},
		// "%%g": the second percent restarts the escape, then 'g' breaks it.
		'{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h67, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		// "%az": one hex digit then a non-hex byte gives three literals.
		'{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h61, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h7A, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		// A lone percent as the final byte passes literally with last set.
		'{8'h25, 1'b1, 1'b1, 2'd1, 8'h25, 8'h00, 8'h00, 1'b1},
		// Final byte arrives while only the percent is held: flushed.
		'{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h41, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		// An escape completed by the final byte carries the last flag.
		'{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h30, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h31, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		// ':' sits just above '9' and must not count as a digit.
		'{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h39, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{8'h3A, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0}
	};

	logic clk;
	logic arst_n;

	pct_in_if  enc_bus ();
	pct_out_if dec_bus ();

	percent_decoder_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc_bus),
		.dec    (dec_bus)
	);

	// Local copy of the decoder state and the beats the last byte produced.
	logic [1:0] held_cnt;
	logic [7:0] held_dig;
	logic [7:0] pred_byte [3];
	logic       pred_last [3];

	// Decoded beats still owed by the block, oldest first.
	dec_beat_t decoded_due [$];
	int        mismatches;

	// calm turns off all idling for the final stretch of the run. hold_req
	// asks the receiver for one long stall; hold_served records that it ran.
	bit calm;
	bit hold_req;
	bit hold_served;

	function automatic logic is_hex_char(input logic [7:0] c);
		return ((c >= DIGIT_0) && (c <= DIGIT_9)) || ((c >= UPPER_A) && (c <= UPPER_F)) ||
			((c >= LOWER_A) && (c <= LOWER_F));
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] t;
		begin
			if (c <= DIGIT_9) begin
				t = c - DIGIT_0;
			end else begin
				t = (c | FOLD_CASE) - LOWER_A + 8'd10;
			end
			return t[3:0];
		end
	endfunction

	// Advances the local decoder by one encoded byte and leaves the beats it
	// yields in pred_byte/pred_last. Returns how many beats that is.
	function automatic int decode_char(input logic [7:0] c, input logic fin);
		int n;
		logic [7:0] v;
		begin
			n = 0;
			for (int i = 0; i < 3; i++) begin
				pred_last[i] = 1'b0;
			end
			if (held_cnt == 2'd1) begin
				// A digit after the percent is held, unless the string ends here.
				if (is_hex_char(c) && !fin) begin
					held_dig = c;
					held_cnt = 2'd2;
					return 0;
				end
				pred_byte[0] = PCT_CHAR;
				n = 1;
			end else if (held_cnt == 2'd2) begin
				v = {hex_nibble(held_dig), hex_nibble(c)};
				if (is_hex_char(c) && (v != 8'h00)) begin
					pred_byte[0] = v;
					pred_last[0] = fin;
					held_cnt = 2'd0;
					held_dig = 8'h00;
					return 1;
				end
				// Broken escape or "%00": the held pair goes out literally.
				pred_byte[0] = PCT_CHAR;
				pred_byte[1] = held_dig;
				n = 2;
			end
			// The current byte is now looked at afresh.
			held_cnt = 2'd0;
			held_dig = 8'h00;
			if ((c == PCT_CHAR) && !fin) begin
				held_cnt = 2'd1;
			end else begin
				pred_byte[n] = c;
				n++;
			end
			if (fin && (n > 0)) begin
				pred_last[n-1] = 1'b1;
			end
			return n;
		end
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int r;
		begin
			r = $urandom_range(0, 21);
			if (r < 10) begin
				return DIGIT_0 + 8'(r);
			end else if (r < 16) begin
				return LOWER_A + 8'(r - 10);
			end
			return UPPER_A + 8'(r - 16);
		end
	endfunction

	// Any nonzero byte other than a hex digit or a percent.
	function automatic logic [7:0] rand_plain_char();
		logic [7:0] c;
		begin
			c = 8'(($urandom_range(1, 255)));
			while (is_hex_char(c) || (c == PCT_CHAR)) begin
				c = 8'(($urandom_range(1, 255)));
			end
			return c;
		end
	endfunction

	// Offers one encoded byte on enc, waits for the handshake, and records
	// the beats it should produce. Entered and left just after a falling edge.
	task automatic send_char(input enc_row_t r);
		int n;
		logic [7:0] d;
		begin
			if (!calm && ($urandom_range(0, 4) == 0)) begin
				enc_bus.valid = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			enc_bus.valid   = 1'b1;
			enc_bus.in_byte = r.b;
			enc_bus.in_last = r.l;
			@(posedge clk);
			while (!enc_bus.ready) begin
				@(posedge clk);
			end
			// The beat was accepted at this edge; the model moves in step.
			n = decode_char(r.b, r.l);
			if (r.fixed) begin
				for (int i = 0; i < int'(r.n); i++) begin
					d = (i == 0) ? r.e0 : ((i == 1) ? r.e1 : r.e2);
					decoded_due.push_back('{d, (i == int'(r.n) - 1) ? r.el : 1'b0});
				end
			end else begin
				for (int i = 0; i < n; i++) begin
					decoded_due.push_back('{pred_byte[i], pred_last[i]});
				end
			end
			@(negedge clk);
		end
	endtask

	// Free-running clock with a 10 ns period.
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Reset is asserted at the start, released just after a falling edge, and never asserted again.
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Receiver: ready changes at the falling edge only. It stalls in random
	// bursts, and once, on request, for a long stretch so that the decoder's
	// command queue fills and the enc side has to back off.
	initial begin
		dec_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_served) begin
				dec_bus.ready = 1'b0;
				hold_served   = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				dec_bus.ready = 1'b1;
			end else if (!calm && ($urandom_range(0, 5) == 0)) begin
				dec_bus.ready = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				dec_bus.ready = 1'b1;
			end else begin
				dec_bus.ready = 1'b1;
			end
		end
	end

	// Checker: every decoded beat taken at a rising edge is matched against
	// the oldest outstanding expectation.
	always @(posedge clk) begin
		dec_beat_t want;
		if (arst_n && dec_bus.valid && dec_bus.ready) begin
			if (decoded_due.size() == 0) begin
				$display("%0t: decoded beat byte %h last %b arrived with nothing expected",
					$time, dec_bus.out_byte, dec_bus.out_last);
				mismatches++;
			end else begin
				want = decoded_due.pop_front();
				if (dec_bus.out_byte !== want.data) begin
					$display("%0t: out_byte mismatch, expected %h, got %h",
						$time, want.data, dec_bus.out_byte);
					mismatches++;
				end
				if (dec_bus.out_last !== want.last) begin
					$display("%0t: out_last mismatch on byte %h, expected %b, got %b",
						$time, want.data, want.last, dec_bus.out_last);
					mismatches++;
				end
			end
		end
	end

	// Sender: directed table first, then random strings, then the drain.
	initial begin
		enc_row_t   row;
		logic [7:0] text [$];
		int         rand_sent;
		int         pieces;
		bit         drained;
		held_cnt        = 2'd0;
		held_dig        = 8'h00;
		mismatches      = 0;
		calm            = 1'b0;
		hold_req        = 1'b0;
		hold_served     = 1'b0;
		drained         = 1'b0;
		rand_sent       = 0;
		enc_bus.valid   = 1'b0;
		enc_bus.in_byte = 8'h20;
		enc_bus.in_last = 1'b0;
		@(posedge arst_n);
		@(negedge clk);

		for (int i = 0; i < DIRECTED_N; i++) begin
			send_char(DIRECTED[i]);
		end

		// The long receiver stall starts now while the text keeps flowing.
		hold_req = 1'b1;
		row = '0;
		while (rand_sent < RANDOM_CHARS) begin
			if (rand_sent >= CALM_AFTER) begin
				calm = 1'b1;
			end
			// Once, halfway through, stop offering until the block has
			// delivered everything owed.
			if (!drained && (rand_sent >= DRAIN_AT)) begin
				drained = 1'b1;
				enc_bus.valid = 1'b0;
				while (decoded_due.size() != 0) begin
					@(negedge clk);
				end
				@(negedge clk);
			end
			if ($urandom_range(0, 9) == 0) begin
				// Noise: any legal byte with a random end-of-string flag.
				row.b = 8'(($urandom_range(1, 255)));
				row.l = ($urandom_range(0, 3) == 0);
				send_char(row);
				rand_sent++;
			end else begin
				// A well-formed string built from pieces of random content.
				text.delete();
				pieces = $urandom_range(1, 6);
				for (int p = 0; p < pieces; p++) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: begin
							text.push_back(8'(($urandom_range(1, 255))));
							if (text[$] == PCT_CHAR) begin
								text[$] = rand_plain_char();
							end
						end
						4, 5: begin
							text.push_back(PCT_CHAR);
							text.push_back(rand_hex_char());
							text.push_back(rand_hex_char());
						end
						6: begin
							text.push_back(PCT_CHAR);
							text.push_back(DIGIT_0);
							text.push_back(DIGIT_0);
						end
						7: begin
							text.push_back(PCT_CHAR);
							text.push_back(rand_plain_char());
						end
						8: begin
							text.push_back(PCT_CHAR);
							text.push_back(rand_hex_char());
							text.push_back(rand_plain_char());
						end
						default: begin
							// A cut-off escape; at the end of the string it
							// is flushed by the final byte.
							text.push_back(PCT_CHAR);
							if ($urandom_range(0, 1) == 1) begin
								text.push_back(rand_hex_char());
							end
						end
					endcase
				end
				for (int k = 0; k < text.size(); k++) begin
					row.b = text[k];
					row.l = (k == text.size() - 1);
					send_char(row);
					rand_sent++;
				end
			end
		end

		enc_bus.valid = 1'b0;
		while (decoded_due.size() != 0) begin
			@(posedge clk);
		end
		// The tail wait catches any stray beat after the last expected one.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* percent_decoder_unit.f */
sv/pct_pkg.sv
sv/pct_in_if.sv
sv/pct_out_if.sv
sv/pct_front.sv
sv/pct_queue.sv
sv/pct_back.sv
sv/percent_decoder_unit.sv
tb/tb_top.sv
